// ----- rtl/eikonal_local_update_2d_core_macros.svh -----
// assertion helpers used by eikonal_local_update_2d_core
`ifndef EIKONAL_LOCAL_UPDATE_2D_CORE_MACROS_SVH
`define EIKONAL_LOCAL_UPDATE_2D_CORE_MACROS_SVH

// a property that must hold at every clock edge outside reset
`define ELU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// an implication checked at every clock edge outside reset
`define ELU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/elu_pkg.sv -----
// ----------------------------------------------------------------------------
// elu_pkg
// Types and constants of the 2d eikonal local update core.
// ----------------------------------------------------------------------------
`default_nettype none

package elu_pkg;

  // input beat
  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [31:0] center_time;
    logic [31:0] west_time;
    logic [31:0] east_time;
    logic [31:0] north_time;
    logic [31:0] south_time;
    logic [15:0] speed;
  } elu_in_t;

  // output beat
  typedef struct packed {
    logic [31:0] new_time;
    logic        unreachable;
  } elu_out_t;

  localparam int GridSideMaxDef = 1024;

  // register map, word index
  localparam logic [1:0] RegGridSize   = 2'd0;
  localparam logic [1:0] RegGridStep   = 2'd1;
  localparam logic [1:0] RegKnownLimit = 2'd2;

  localparam logic [10:0] GridSizeRst   = 11'd1024;
  localparam logic [31:0] GridStepRst   = 32'd65536;
  localparam logic [31:0] KnownLimitRst = 32'd65536000;

  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

  // divider: 40 quotient bits, 4 per stage
  localparam int DivPerStage = 4;
  localparam int DivStages   = 10;
  // square root: 32 result bits, 2 per stage
  localparam int SqPerStage  = 2;
  localparam int SqStages    = 16;

  // candidate summary after the neighbor pick
  typedef struct packed {
    logic        unreach;
    logic        two;
    logic [31:0] t0;
    logic [31:0] t1;
  } elu_side_t;

  // one divider stage
  typedef struct packed {
    elu_side_t   side;
    logic [15:0] speed;
    logic [15:0] rem;
    logic [39:0] num;
    logic [39:0] quo;
  } elu_div_t;

  // what the last stage needs
  typedef struct packed {
    logic        unreach;
    logic        use_root;
    logic [31:0] direct;
    logic [31:0] half;
  } elu_fin_t;

  // squares
  typedef struct packed {
    elu_fin_t    fin;
    logic [63:0] a;
    logic [63:0] dd;
  } elu_mul_t;

  // one square root stage
  typedef struct packed {
    elu_fin_t    fin;
    logic [63:0] x;
    logic [63:0] res;
  } elu_sq_t;

endpackage

`default_nettype wire

// ----- rtl/eikonal_local_update_2d_core.sv -----
// ----------------------------------------------------------------------------
// eikonal_local_update_2d_core
// Upwind update of one point of a 2d eikonal grid, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one beat per grid point (row, col, center and four neighbor
//   times in Q16.16, speed in Q8.8), taken when in_valid_i is high and
//   in_stall_o is low. out channel: one beat per input beat, in order, with
//   the new time and the unreachable flag, taken when out_stall_i is low.
//   Config registers over APB: grid_size at 0x0, grid_step at 0x4,
//   known_limit at 0x8; write only while no beat is in flight.
//   Pipeline from input beat to output beat: input register,
//   neighbor pick, a 10-stage radix-2 divider (4 quotient bits a stage),
//   a squaring stage, a discriminant stage, 16 square root stages (2 result
//   bits a stage) and the output register. Throughput is one beat per cycle
//   while no output beat is stalled. Reset clears all valid bits and loads
//   the register defaults. When the receiver stalls a full output register,
//   the whole pipeline holds and in_stall_o rises in the same cycle; bubbles
//   inside the pipeline are not squeezed out while it holds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "eikonal_local_update_2d_core_macros.svh"

module eikonal_local_update_2d_core #(
  parameter int GRID_SIDE_MAX = elu_pkg::GridSideMaxDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire elu_pkg::elu_in_t in_data_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output elu_pkg::elu_out_t     out_data_o,
  // config port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import elu_pkg::*;

  localparam logic [16:0] SideMax = 17'(GRID_SIDE_MAX);

  // config registers
  logic [10:0] grid_size_q;
  logic [31:0] grid_step_q, known_limit_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q   <= GridSizeRst;
      grid_step_q   <= GridStepRst;
      known_limit_q <= KnownLimitRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegGridSize:   grid_size_q   <= pwdata[10:0];
        RegGridStep:   grid_step_q   <= pwdata;
        RegKnownLimit: known_limit_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[3:2])
      RegGridSize:   prdata = {21'd0, grid_size_q};
      RegGridStep:   prdata = grid_step_q;
      RegKnownLimit: prdata = known_limit_q;
      default:       prdata = 32'd0;
    endcase
  end

  // pipeline advance: hold only when a finished beat is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic     in_v_q;
  elu_in_t  in_q;
  logic     div_v_q [DivStages+1];
  elu_div_t div_q   [DivStages+1];
  elu_div_t div_in;
  elu_div_t div_d   [1:DivStages];
  logic     mul_v_q;
  elu_mul_t mul_q, mul_d;
  logic     sq_v_q  [SqStages+1];
  elu_sq_t  sq_q    [SqStages+1];
  elu_sq_t  sq_in;
  elu_sq_t  sq_d    [1:SqStages];
  logic     out_v_q;
  elu_out_t out_q, out_d;

  // neighbor pick and candidate sort
  logic [10:0] n_eff, n_m1;
  logic [31:0] pick_c, pick_r;
  logic        c_ok, r_ok;
  elu_side_t   side;

  always_comb begin
    n_eff = (17'(grid_size_q) > SideMax) ? SideMax[10:0] : grid_size_q;
    n_m1  = n_eff - 11'd1;
    if (in_q.col == 10'd0) begin
      pick_c = in_q.east_time;
    end else if (n_eff != 11'd0 && {1'b0, in_q.col} == n_m1) begin
      pick_c = in_q.west_time;
    end else begin
      pick_c = (in_q.west_time < in_q.east_time) ? in_q.west_time : in_q.east_time;
    end
    if (in_q.row == 10'd0) begin
      pick_r = in_q.south_time;
    end else if (n_eff != 11'd0 && {1'b0, in_q.row} == n_m1) begin
      pick_r = in_q.north_time;
    end else begin
      pick_r = (in_q.north_time < in_q.south_time) ? in_q.north_time : in_q.south_time;
    end
    c_ok = (pick_c < known_limit_q) && (pick_c < in_q.center_time);
    r_ok = (pick_r < known_limit_q) && (pick_r < in_q.center_time);
    side.two     = c_ok && r_ok;
    side.unreach = !(c_ok || r_ok) || (in_q.speed == 16'd0);
    if (c_ok && r_ok) begin
      side.t0 = (pick_c < pick_r) ? pick_c : pick_r;
      side.t1 = (pick_c < pick_r) ? pick_r : pick_c;
    end else begin
      side.t0 = c_ok ? pick_c : pick_r;
      side.t1 = side.t0;
    end
    div_in.side  = side;
    div_in.speed = in_q.speed;
    div_in.rem   = 16'd0;
    div_in.num   = {grid_step_q, 8'd0};
    div_in.quo   = 40'd0;
  end

  // restoring divider stages
  always_comb begin
    elu_div_t    v;
    logic [16:0] trial;
    for (int s = 1; s <= DivStages; s++) begin
      v = div_q[s-1];
      for (int k = 0; k < DivPerStage; k++) begin
        trial = {v.rem, v.num[39]};
        v.num = {v.num[38:0], 1'b0};
        if (trial >= {1'b0, v.speed}) begin
          v.rem = 16'(trial - {1'b0, v.speed});
          v.quo = {v.quo[38:0], 1'b1};
        end else begin
          v.rem = trial[15:0];
          v.quo = {v.quo[38:0], 1'b0};
        end
      end
      div_d[s] = v;
    end
  end

  // one-sided value, branch choice and squares
  logic [31:0] u_sat, dlt;
  logic [32:0] one_sided, pair_sum;
  always_comb begin
    u_sat     = (|div_q[DivStages].quo[39:32]) ? TimeMax : div_q[DivStages].quo[31:0];
    one_sided = {1'b0, div_q[DivStages].side.t0} + {1'b0, u_sat};
    pair_sum  = {1'b0, div_q[DivStages].side.t0} + {1'b0, div_q[DivStages].side.t1};
    dlt       = div_q[DivStages].side.t1 - div_q[DivStages].side.t0;
    mul_d.fin.unreach  = div_q[DivStages].side.unreach;
    mul_d.fin.use_root = div_q[DivStages].side.two
                         && (one_sided >= {1'b0, div_q[DivStages].side.t1});
    mul_d.fin.direct   = one_sided[32] ? TimeMax : one_sided[31:0];
    mul_d.fin.half     = pair_sum[32:1];
    mul_d.a            = 64'(u_sat) * 64'(u_sat);
    mul_d.dd           = 64'(dlt) * 64'(dlt);
  end

  // quarter of the discriminant
  logic [65:0] disc;
  always_comb begin
    disc      = {2'b0, mul_q.a} + {2'b0, mul_q.a} - {2'b0, mul_q.dd};
    sq_in.fin = mul_q.fin;
    sq_in.x   = disc[65:2];
    sq_in.res = 64'd0;
  end

  // square root stages
  always_comb begin
    elu_sq_t     v;
    logic [63:0] bitv, trial;
    for (int s = 1; s <= SqStages; s++) begin
      v = sq_q[s-1];
      for (int k = 0; k < SqPerStage; k++) begin
        bitv  = 64'd1 << (62 - 2 * ((s - 1) * SqPerStage + k));
        trial = v.res + bitv;
        if (v.x >= trial) begin
          v.x   = v.x - trial;
          v.res = (v.res >> 1) + bitv;
        end else begin
          v.res = v.res >> 1;
        end
      end
      sq_d[s] = v;
    end
  end

  // final select and saturation
  logic [32:0] root_sum;
  always_comb begin
    root_sum = {1'b0, sq_q[SqStages].fin.half} + {1'b0, sq_q[SqStages].res[31:0]};
    out_d.unreachable = sq_q[SqStages].fin.unreach;
    if (sq_q[SqStages].fin.unreach) begin
      out_d.new_time = TimeMax;
    end else if (sq_q[SqStages].fin.use_root) begin
      out_d.new_time = root_sum[32] ? TimeMax : root_sum[31:0];
    end else begin
      out_d.new_time = sq_q[SqStages].fin.direct;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s <= DivStages; s++) div_v_q[s] <= 1'b0;
      for (int s = 0; s <= SqStages; s++)  sq_v_q[s]  <= 1'b0;
    end else if (en) begin
      in_v_q     <= in_valid_i;
      div_v_q[0] <= in_v_q;
      for (int s = 1; s <= DivStages; s++) div_v_q[s] <= div_v_q[s-1];
      mul_v_q    <= div_v_q[DivStages];
      sq_v_q[0]  <= mul_v_q;
      for (int s = 1; s <= SqStages; s++) sq_v_q[s] <= sq_v_q[s-1];
      out_v_q    <= sq_v_q[SqStages];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q     <= in_data_i;
      div_q[0] <= div_in;
      for (int s = 1; s <= DivStages; s++) div_q[s] <= div_d[s];
      mul_q    <= mul_d;
      sq_q[0]  <= sq_in;
      for (int s = 1; s <= SqStages; s++) sq_q[s] <= sq_d[s];
      out_q    <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  logic [DivStages+SqStages+4:0] v_vec;
  always_comb begin
    v_vec[0] = in_v_q;
    for (int s = 0; s <= DivStages; s++) v_vec[1+s] = div_v_q[s];
    v_vec[DivStages+2] = mul_v_q;
    for (int s = 0; s <= SqStages; s++) v_vec[DivStages+3+s] = sq_v_q[s];
    v_vec[DivStages+SqStages+4] = out_v_q;
  end

  `ELU_ASSERT(a_unreach_max, clk_i, rst_ni,
    !(out_valid_o && out_data_o.unreachable) || (out_data_o.new_time == TimeMax),
    "unreachable beat without saturated time")
  `ELU_ASSERT_NEXT(a_hold_valids, clk_i, rst_ni, !en, $stable(v_vec),
    "pipeline moved while output was stalled")
  `ELU_ASSERT(a_root_width, clk_i, rst_ni,
    !sq_v_q[SqStages] || (sq_q[SqStages].res[63:32] == 32'd0),
    "square root result wider than 32 bits")

endmodule

`default_nettype wire
